### hw/rtl/tcde_pkg.sv
package tcde_pkg;

   localparam int CACHE_SLOTS = 16;
   localparam int GRID_SIZE   = 64;

   localparam int SLOT_W  = $clog2(CACHE_SLOTS);
   localparam int COORD_W = 6;
   localparam int TILE_W  = 2 * COORD_W;
   localparam int DIST_W  = COORD_W + 1;
   localparam int REQ_W   = 8;
   localparam int RSP_SLOT_W = 4;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);

   typedef enum logic [1:0] {
      STATUS_REJECT = 2'd0,
      STATUS_HIT    = 2'd1,
      STATUS_FILL   = 2'd2,
      STATUS_EVICT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   // one slot read back from the tile memory
   typedef struct packed {
      logic              clear;
      logic              vld;
      logic [SLOT_W-1:0] idx;
      logic              slot_valid;
   } scan_beat_type;

   // running outcome of the slot scan
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] hit_idx;
      logic              free_found;
      logic [SLOT_W-1:0] free_idx;
      logic [SLOT_W-1:0] victim_idx;
      logic [TILE_W-1:0] victim_tile;
   } scan_result_type;

endpackage

### hw/rtl/tcde_tile_ram.sv
module tcde_tile_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tcde_scan_unit.sv
module tcde_scan_unit (
   input  logic                             clock,
   input  tcde_pkg::scan_beat_type          beat,
   input  logic [tcde_pkg::TILE_W-1:0]      tile,
   input  logic [tcde_pkg::TILE_W-1:0]      key,
   input  logic [tcde_pkg::COORD_W-1:0]     centre_x,
   input  logic [tcde_pkg::COORD_W-1:0]     centre_z,
   output tcde_pkg::scan_result_type        result
);

   tcde_pkg::scan_result_type       res_ff;
   tcde_pkg::scan_result_type       res_in;
   logic [tcde_pkg::DIST_W-1:0]     best_ff;
   logic [tcde_pkg::DIST_W-1:0]     best_in;
   logic [tcde_pkg::COORD_W-1:0]    tx;
   logic [tcde_pkg::COORD_W-1:0]    tz;
   logic [tcde_pkg::COORD_W-1:0]    dx;
   logic [tcde_pkg::COORD_W-1:0]    dz;
   logic [tcde_pkg::DIST_W-1:0]     tile_dist;

   assign tx        = tile[tcde_pkg::TILE_W-1:tcde_pkg::COORD_W];
   assign tz        = tile[tcde_pkg::COORD_W-1:0];
   assign dx        = (tx > centre_x) ? (tx - centre_x) : (centre_x - tx);
   assign dz        = (tz > centre_z) ? (tz - centre_z) : (centre_z - tz);
   assign tile_dist = {1'b0, dx} + {1'b0, dz};

   always_comb begin
      res_in  = res_ff;
      best_in = best_ff;
      if (beat.clear) begin
         res_in.hit        = 1'b0;
         res_in.free_found = 1'b0;
         best_in           = '0;
      end else if (beat.vld) begin
         if (beat.slot_valid && (tile == key)) begin
            res_in.hit     = 1'b1;
            res_in.hit_idx = beat.idx;
         end
         if (!beat.slot_valid && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            res_in.free_idx   = beat.idx;
         end
         // slot 0 seeds the victim; later slots take over only when strictly farther
         if ((beat.idx == '0) || (tile_dist > best_ff)) begin
            best_in            = tile_dist;
            res_in.victim_idx  = beat.idx;
            res_in.victim_tile = tile;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      best_ff <= best_in;
   end

   assign result = res_ff;

endmodule

### hw/rtl/tile_cache_distance_evict_unit.sv
// Tile cache with farthest-tile replacement, 16 fully associative slots.
//
// Request channel (req_*): tile column/row (signed), the viewer's centre tile
// and a present flag. An item is taken when req_valid is high and req_stall
// is low. Result channel (rsp_*): status, slot and, on an eviction, the
// coordinates of the tile that was thrown out; one result per request.
//
// Each request walks every slot of the tile memory, one slot per cycle, to
// find a hit, the lowest free slot and the farthest held tile in one pass.
// The memory read port sets the pace. An out-of-grid or absent tile skips
// the walk. The result is loaded into the output register at the finish
// step, after the walk ends; only then can the next request be taken.
//
// req_stall is high while an item is in flight. A stalled result sits in the
// output register; the next item is still taken and walked, and its result
// waits at the finish step until the output register frees up.
// Reset empties the cache (all valid bits cleared) and drops any item in
// flight; the tile memory itself is not cleared.
module tile_cache_distance_evict_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tcde_pkg::REQ_W-1:0] req_tile_x,
   input  logic signed [tcde_pkg::REQ_W-1:0] req_tile_z,
   input  logic [tcde_pkg::COORD_W-1:0]      req_centre_x,
   input  logic [tcde_pkg::COORD_W-1:0]      req_centre_z,
   input  logic                              req_tile_exists,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [tcde_pkg::RSP_SLOT_W-1:0]   rsp_slot,
   output logic [tcde_pkg::COORD_W-1:0]      rsp_evicted_x,
   output logic [tcde_pkg::COORD_W-1:0]      rsp_evicted_z
);

   localparam int SW = tcde_pkg::SLOT_W;

   tcde_pkg::fsm_type               state_ff, state_in;

   // request held for the duration of the walk
   logic [tcde_pkg::TILE_W-1:0]     key_ff, key_in;
   logic [tcde_pkg::COORD_W-1:0]    cx_ff, cx_in;
   logic [tcde_pkg::COORD_W-1:0]    cz_ff, cz_in;
   logic                            reject_ff, reject_in;

   // memory walk
   logic [SW-1:0]                   rd_idx_ff, rd_idx_in;
   logic                            issued_all_ff, issued_all_in;
   logic                            beat_vld_ff, beat_vld_in;
   logic [SW-1:0]                   beat_idx_ff, beat_idx_in;
   logic [tcde_pkg::CACHE_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   tcde_pkg::status_type            status_ff, status_in;
   logic [tcde_pkg::RSP_SLOT_W-1:0] slot_ff, slot_in;
   logic [tcde_pkg::COORD_W-1:0]    ex_ff, ex_in;
   logic [tcde_pkg::COORD_W-1:0]    ez_ff, ez_in;

   logic                            accept;
   logic                            x_in_grid;
   logic                            z_in_grid;
   logic                            reject_now;
   logic                            rd_en;
   logic                            rsp_load;
   logic                            scan_last;
   logic                            wr_en;
   logic [SW-1:0]                   wr_slot;
   logic [tcde_pkg::TILE_W-1:0]     rd_tile;
   tcde_pkg::scan_beat_type         beat;
   tcde_pkg::scan_result_type       scan_res;

   // ---------------------------------------------------------------- input
   assign accept = req_valid && !req_stall;

   assign x_in_grid = !req_tile_x[tcde_pkg::REQ_W-1] &&
                      ({1'b0, req_tile_x[tcde_pkg::REQ_W-2:0]} <
                       tcde_pkg::REQ_W'(tcde_pkg::GRID_SIZE));
   assign z_in_grid = !req_tile_z[tcde_pkg::REQ_W-1] &&
                      ({1'b0, req_tile_z[tcde_pkg::REQ_W-2:0]} <
                       tcde_pkg::REQ_W'(tcde_pkg::GRID_SIZE));
   assign reject_now = !(x_in_grid && z_in_grid && req_tile_exists);

   // --------------------------------------------------------- state machine
   assign scan_last = beat_vld_ff && (beat_idx_ff == tcde_pkg::LAST_SLOT);
   assign rsp_load  = (state_ff == tcde_pkg::FSM_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcde_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = reject_now ? tcde_pkg::FSM_FINISH : tcde_pkg::FSM_SCAN;
            end
         end
         tcde_pkg::FSM_SCAN: begin
            if (scan_last) begin
               state_in = tcde_pkg::FSM_FINISH;
            end
         end
         tcde_pkg::FSM_FINISH: begin
            if (rsp_load) begin
               state_in = tcde_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = tcde_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      case (state_ff)
         tcde_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
         end
         tcde_pkg::FSM_SCAN: begin
            rd_en = !issued_all_ff;
         end
         tcde_pkg::FSM_FINISH: begin
            rd_en = 1'b0;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ----------------------------------------------------- request capture
   always_comb begin
      key_in    = key_ff;
      cx_in     = cx_ff;
      cz_in     = cz_ff;
      reject_in = reject_ff;
      if (accept) begin
         key_in    = {req_tile_x[tcde_pkg::COORD_W-1:0], req_tile_z[tcde_pkg::COORD_W-1:0]};
         cx_in     = req_centre_x;
         cz_in     = req_centre_z;
         reject_in = reject_now;
      end
   end

   // ----------------------------------------------------------- slot walk
   // Issue one read address per cycle; the data and its slot number line up
   // in the following cycle as a beat for the scan unit.
   always_comb begin
      rd_idx_in     = rd_idx_ff;
      issued_all_in = issued_all_ff;
      if (accept) begin
         rd_idx_in     = '0;
         issued_all_in = 1'b0;
      end else if (rd_en) begin
         rd_idx_in = rd_idx_ff + SW'(1);
         if (rd_idx_ff == tcde_pkg::LAST_SLOT) begin
            issued_all_in = 1'b1;
         end
      end
   end

   assign beat_vld_in = rd_en;
   assign beat_idx_in = rd_idx_ff;

   assign beat.clear      = accept;
   assign beat.vld        = beat_vld_ff;
   assign beat.idx        = beat_idx_ff;
   assign beat.slot_valid = slot_valid_ff[beat_idx_ff];

   // ------------------------------------------------------ finish / write
   // Write back only on a fill or eviction; reads and writes never overlap
   // because the walk has ended before the finish step.
   assign wr_en   = rsp_load && !reject_ff && !scan_res.hit;
   assign wr_slot = scan_res.free_found ? scan_res.free_idx : scan_res.victim_idx;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (wr_en) begin
         slot_valid_in[wr_slot] = 1'b1;
      end
   end

   always_comb begin
      status_in = status_ff;
      slot_in   = slot_ff;
      ex_in     = ex_ff;
      ez_in     = ez_ff;
      if (rsp_load) begin
         ex_in = '0;
         ez_in = '0;
         if (reject_ff) begin
            status_in = tcde_pkg::STATUS_REJECT;
            slot_in   = '0;
         end else if (scan_res.hit) begin
            status_in = tcde_pkg::STATUS_HIT;
            slot_in   = tcde_pkg::RSP_SLOT_W'(scan_res.hit_idx);
         end else if (scan_res.free_found) begin
            status_in = tcde_pkg::STATUS_FILL;
            slot_in   = tcde_pkg::RSP_SLOT_W'(scan_res.free_idx);
         end else begin
            status_in = tcde_pkg::STATUS_EVICT;
            slot_in   = tcde_pkg::RSP_SLOT_W'(scan_res.victim_idx);
            ex_in     = scan_res.victim_tile[tcde_pkg::TILE_W-1:tcde_pkg::COORD_W];
            ez_in     = scan_res.victim_tile[tcde_pkg::COORD_W-1:0];
         end
      end
   end

   // hold the result while stalled, drop it once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcde_pkg::FSM_IDLE;
         issued_all_ff <= 1'b1;
         beat_vld_ff   <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issued_all_ff <= issued_all_in;
         beat_vld_ff   <= beat_vld_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      cx_ff       <= cx_in;
      cz_ff       <= cz_in;
      reject_ff   <= reject_in;
      rd_idx_ff   <= rd_idx_in;
      beat_idx_ff <= beat_idx_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
      ex_ff       <= ex_in;
      ez_ff       <= ez_in;
   end

   // ---------------------------------------------------------- submodules
   tcde_tile_ram #(
      .DEPTH (tcde_pkg::CACHE_SLOTS),
      .WIDTH (tcde_pkg::TILE_W)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_tile)
   );

   tcde_scan_unit u_scan (
      .clock    (clock),
      .beat     (beat),
      .tile     (rd_tile),
      .key      (key_ff),
      .centre_x (cx_ff),
      .centre_z (cz_ff),
      .result   (scan_res)
   );

   // -------------------------------------------------------------- outputs
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_evicted_x = ex_ff;
   assign rsp_evicted_z = ez_ff;

endmodule

### sim/tile_cache_check_pkg.sv
package tile_cache_check_pkg;
   import tcde_pkg::*;

   typedef struct {
      status_type             status;
      logic [RSP_SLOT_W-1:0]  slot;
      logic [COORD_W-1:0]     evicted_x;
      logic [COORD_W-1:0]     evicted_z;
   } tile_result_type;

   class tile_slot_scoreboard;
      bit                slot_held[CACHE_SLOTS];
      logic [TILE_W-1:0] slot_tile[CACHE_SLOTS];
      tile_result_type   awaited[$];
      int                mismatches;
      int                results;
      int                hits;
      int                fills;
      int                evictions;
      int                rejects;

      function new();
         foreach (slot_held[i]) slot_held[i] = 1'b0;
         mismatches = 0;
         results    = 0;
         hits       = 0;
         fills      = 0;
         evictions  = 0;
         rejects    = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Update the cache image for one accepted request and queue its result.
      function void note_request(logic signed [REQ_W-1:0] tile_x,
                                 logic signed [REQ_W-1:0] tile_z,
                                 logic [COORD_W-1:0] centre_x,
                                 logic [COORD_W-1:0] centre_z,
                                 logic present);
         tile_result_type   r;
         logic [TILE_W-1:0] key;
         bit                hit;
         int                free_idx;
         int                victim;
         int                best;
         int                tile_dist;
         int                sx;
         int                sz;

         r.status    = STATUS_REJECT;
         r.slot      = '0;
         r.evicted_x = '0;
         r.evicted_z = '0;
         if (present && tile_x >= 0 && tile_z >= 0 &&
             tile_x < GRID_SIZE && tile_z < GRID_SIZE) begin
            key = {tile_x[COORD_W-1:0], tile_z[COORD_W-1:0]};
            hit = 1'b0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
               if (!hit && slot_held[i] && slot_tile[i] == key) begin
                  hit      = 1'b1;
                  r.status = STATUS_HIT;
                  r.slot   = RSP_SLOT_W'(i);
               end
            end
            if (!hit) begin
               free_idx = -1;
               for (int i = 0; i < CACHE_SLOTS; i++) begin
                  if (!slot_held[i] && free_idx < 0) free_idx = i;
               end
               if (free_idx >= 0) begin
                  r.status = STATUS_FILL;
               end else begin
                  // farthest held tile goes; strict compare keeps the lowest slot on ties
                  victim = 0;
                  best   = 0;
                  for (int i = 0; i < CACHE_SLOTS; i++) begin
                     sx        = int'(slot_tile[i][TILE_W-1:COORD_W]);
                     sz        = int'(slot_tile[i][COORD_W-1:0]);
                     tile_dist = (sx > int'(centre_x) ? sx - int'(centre_x)
                                                      : int'(centre_x) - sx) +
                                 (sz > int'(centre_z) ? sz - int'(centre_z)
                                                      : int'(centre_z) - sz);
                     if (tile_dist > best) begin
                        best   = tile_dist;
                        victim = i;
                     end
                  end
                  r.status    = STATUS_EVICT;
                  r.evicted_x = slot_tile[victim][TILE_W-1:COORD_W];
                  r.evicted_z = slot_tile[victim][COORD_W-1:0];
                  free_idx    = victim;
               end
               slot_held[free_idx] = 1'b1;
               slot_tile[free_idx] = key;
               r.slot              = RSP_SLOT_W'(free_idx);
            end
         end
         awaited.push_back(r);
      endfunction

      // Compare one accepted result with the oldest queued one.
      function void check_result(status_type status,
                                 logic [RSP_SLOT_W-1:0] slot,
                                 logic [COORD_W-1:0] evicted_x,
                                 logic [COORD_W-1:0] evicted_z);
         tile_result_type e;

         results++;
         if (awaited.size() == 0) begin
            $display("%0t: result with nothing queued: status %0d slot %0d evicted %0d,%0d",
                     $time, status, slot, evicted_x, evicted_z);
            mismatches++;
            return;
         end
         e = awaited.pop_front();
         case (e.status)
            STATUS_HIT:   hits++;
            STATUS_FILL:  fills++;
            STATUS_EVICT: evictions++;
            default:      rejects++;
         endcase
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            mismatches++;
         end
         if (slot !== e.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, e.slot, slot);
            mismatches++;
         end
         if (evicted_x !== e.evicted_x) begin
            $display("%0t: evicted_x expected %0d actual %0d", $time, e.evicted_x, evicted_x);
            mismatches++;
         end
         if (evicted_z !== e.evicted_z) begin
            $display("%0t: evicted_z expected %0d actual %0d", $time, e.evicted_z, evicted_z);
            mismatches++;
         end
      endfunction
   endclass

endpackage

### sim/tb_top.sv
module tb_top;
   import tcde_pkg::*;
   import tile_cache_check_pkg::*;

   localparam int ITEM_TOTAL     = 1150;
   localparam int DIRECTED_ITEMS = 25;
   localparam int WATCHDOG_LIMIT = 500;
   // time for a cached-tile item to walk every slot, with margin
   localparam int DRAIN_CYCLES   = CACHE_SLOTS + 8;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic signed [REQ_W-1:0]   req_tile_x      = '0;
   logic signed [REQ_W-1:0]   req_tile_z      = '0;
   logic [COORD_W-1:0]        req_centre_x    = '0;
   logic [COORD_W-1:0]        req_centre_z    = '0;
   logic                      req_tile_exists = 1'b0;
   logic                      rsp_stall       = 1'b0;
   logic                      req_stall;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [RSP_SLOT_W-1:0]     rsp_slot;
   logic [COORD_W-1:0]        rsp_evicted_x;
   logic [COORD_W-1:0]        rsp_evicted_z;

   tile_slot_scoreboard sb;

   // when set, neither side inserts idle cycles
   bit no_idle = 1'b0;
   int cur_cx  = 32;
   int cur_cz  = 32;
   int noise_count = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   tile_cache_distance_evict_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tile_x      (req_tile_x),
      .req_tile_z      (req_tile_z),
      .req_centre_x    (req_centre_x),
      .req_centre_z    (req_centre_z),
      .req_tile_exists (req_tile_exists),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_evicted_x   (rsp_evicted_x),
      .rsp_evicted_z   (rsp_evicted_z)
   );

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, sb.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int pick_wait();
      return no_idle ? 0 : int'($urandom_range(0, 10));
   endfunction

   // Drive one request, hold it until taken, then log it with the scoreboard.
   // Each step sees at most one assignment to req_valid: lower it only when a
   // gap is drawn, otherwise keep it high into the next item.
   task automatic send_request(input int tile_x, input int tile_z,
                               input int centre_x, input int centre_z,
                               input bit present);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_tile_x      <= REQ_W'(tile_x);
      req_tile_z      <= REQ_W'(tile_z);
      req_centre_x    <= COORD_W'(centre_x);
      req_centre_z    <= COORD_W'(centre_z);
      req_tile_exists <= present;
      // values read right after the edge are the ones the block sampled
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(REQ_W'(tile_x), REQ_W'(tile_z),
                      COORD_W'(centre_x), COORD_W'(centre_z), present);
   endtask

   // Result side: stall for a drawn number of cycles, then take the next result.
   task automatic collect_results();
      int hold;
      forever begin
         hold = pick_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(status_type'(rsp_status), rsp_slot, rsp_evicted_x, rsp_evicted_z);
      end
   endtask

   // Directed part: rejects at the field extremes, fills up the cache, a hit,
   // then evictions including a distance tie between two slots.
   task automatic run_directed();
      send_request(-128, 0, 0, 0, 1'b1);        // most negative column
      send_request(127, 5, 0, 0, 1'b1);         // largest column, far off grid
      send_request(3, -1, 63, 63, 1'b1);        // row just below the grid
      send_request(63, 64, 63, 0, 1'b1);        // row just past the grid
      send_request(10, 10, 10, 10, 1'b0);       // tile marked absent
      send_request(0, 0, 0, 0, 1'b1);           // slot 0
      send_request(63, 63, 63, 63, 1'b1);       // slot 1
      send_request(0, 0, 0, 63, 1'b1);          // hit on slot 0
      for (int i = 1; i <= 14; i++) begin
         send_request(i, 1, 31, 32, 1'b1);      // fill the remaining slots
      end
      // (0,0) and (63,63) are both 63 away from (31,32): lowest slot loses
      send_request(40, 40, 31, 32, 1'b1);
      // from the origin corner, (63,63) is the farthest
      send_request(2, 2, 0, 0, 1'b1);
      send_request(40, 40, 0, 0, 1'b1);
   endtask

   // Random part: mostly tiles near a drifting viewer center, so that hits,
   // fills and evictions all occur; the rest is noise over the whole signed range.
   task automatic run_random(input int count);
      int k;
      int tx;
      int tz;
      int radius;
      bit present;
      for (int n = 0; n < count; n++) begin
         // leave stretches with no idling on either side
         no_idle = (n % 400) >= 320;
         // once, drain everything before going on
         if (n == count / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         k = int'($urandom_range(0, 99));
         if (k == 0) begin
            cur_cx = int'($urandom_range(0, 63));
            cur_cz = int'($urandom_range(0, 63));
         end else if (k == 1) begin
            cur_cx = $urandom_range(0, 1) ? 63 : 0;
            cur_cz = $urandom_range(0, 1) ? 63 : 0;
         end else if (k < 14) begin
            cur_cx = cur_cx + int'($urandom_range(0, 4)) - 2;
            cur_cz = cur_cz + int'($urandom_range(0, 4)) - 2;
            if (cur_cx < 0) cur_cx = 0;
            if (cur_cx > 63) cur_cx = 63;
            if (cur_cz < 0) cur_cz = 0;
            if (cur_cz > 63) cur_cz = 63;
         end
         k = int'($urandom_range(0, 99));
         if (k < 10) begin
            // noise over the whole signed range and any center
            tx      = int'($urandom_range(0, 255));
            tz      = int'($urandom_range(0, 255));
            present = 1'(($urandom_range(0, 1)));
            noise_count++;
            send_request(tx, tz, int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
                         present);
         end else begin
            radius  = int'($urandom_range(1, 3));
            tx      = cur_cx + int'($urandom_range(0, 2 * radius)) - radius;
            tz      = cur_cz + int'($urandom_range(0, 2 * radius)) - radius;
            present = (k >= 14);
            send_request(tx, tz, cur_cx, cur_cz, present);
         end
      end
   endtask

   initial begin
      sb = new();
      // hold reset, then start both sides
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_results();
      join_none
      run_directed();
      run_random(ITEM_TOTAL - DIRECTED_ITEMS);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // watch for stray results after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results: %0d hits, %0d fills, %0d evictions, %0d rejects",
               sb.results, sb.hits, sb.fills, sb.evictions, sb.rejects);
      $display("Traffic followed a drifting viewer center with %0d noise requests mixed in",
               noise_count);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tcde_pkg.sv
hw/rtl/tcde_tile_ram.sv
hw/rtl/tcde_scan_unit.sv
hw/rtl/tile_cache_distance_evict_unit.sv
sim/tile_cache_check_pkg.sv
sim/tb_top.sv
